[design/rgbamf_pkg.sv]
package rgbamf_pkg;

   // Fixed field widths of the pixel, request and register formats.
   localparam int CHAN_W       = 8;
   localparam int PIX_W        = 32;
   localparam int ROW_W        = 13;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int BINS         = 256;
   localparam int SCAN_W       = 9;
   localparam int CSR_W        = 13;
   localparam int CSR_IDX_W    = 2;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CFG_RADIUS_W = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS       = 2'd2;

   // Request opcodes.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Sequencer states.
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CLEAR  = 9'b000000010,
      ST_ALPHA  = 9'b000000100,
      ST_ROWSET = 9'b000001000,
      ST_FETCH  = 9'b000010000,
      ST_HREAD  = 9'b000100000,
      ST_HWRITE = 9'b001000000,
      ST_SCAN   = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

endpackage

[design/rgba_median_filter_core.sv]
// RGBA median filter core.
// Pixels arrive in raster order on the req_ channel (req_op = pixel); each
// pixel of row r > radius makes one filtered pixel of row r-radius-1 on the
// rsp_ channel. Once the whole frame is in, each flush request emits one of
// the remaining pixels, and rsp_frame_end marks the last one of the frame.
// Pixel requests after the frame is complete and flush requests before it
// is complete are taken and dropped without a response.
// Registers are written on the csr_ port; the user must write them only
// while the core is idle, which the core does not enforce. A write to any
// of the three registers restarts the frame. Each emitting request passes,
// from one accepted request to the next, through a setup step, a row setup
// step per window row, a line store read and a histogram read-modify-write
// per window pixel, a scan of the 256-bin histogram memories, which also
// clears them, a hand-off and a return to idle. Non-emitting requests leave
// the core idle. The core takes one request at a time.
// A finished response sits in an output register; the core accepts the
// next request while it waits, and stalls only at the end of the next
// emitting request until the previous response is taken.
// After reset the histogram memories are cleared while req_ready is low;
// registers reset to width 1, height 1, radius 1.
module rgba_median_filter_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [rgbamf_pkg::CHAN_W-1:0]     req_in_red,
   input  logic [rgbamf_pkg::CHAN_W-1:0]     req_in_green,
   input  logic [rgbamf_pkg::CHAN_W-1:0]     req_in_blue,
   input  logic [rgbamf_pkg::CHAN_W-1:0]     req_in_alpha,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rgbamf_pkg::CHAN_W-1:0]     rsp_out_red,
   output logic [rgbamf_pkg::CHAN_W-1:0]     rsp_out_green,
   output logic [rgbamf_pkg::CHAN_W-1:0]     rsp_out_blue,
   output logic [rgbamf_pkg::CHAN_W-1:0]     rsp_out_alpha,
   output logic                              rsp_frame_end,
   input  logic                              csr_write_en,
   input  logic [rgbamf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rgbamf_pkg::CSR_W-1:0]      csr_wdata
);

   import rgbamf_pkg::*;

   localparam int LINES    = 2 * MAX_RADIUS + 2;
   localparam int SLOT_W   = $clog2(LINES);
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int EW_W     = $clog2(MAX_WIDTH + 1);
   localparam int DEPTH    = MAX_WIDTH * LINES;
   localparam int AW       = $clog2(DEPTH);
   localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
   localparam int OFF_W    = RAD_W + 1;
   localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
   localparam int CNT_W    = $clog2(SIDE_MAX * SIDE_MAX + 1);
   localparam int PYW      = ROW_W + 2;
   localparam int PXW      = EW_W + 2;
   localparam int SW       = SLOT_W + 2;
   localparam int BIN_W    = $clog2(BINS);

   state_type state_ff, state_in;

   logic [CFG_WIDTH_W-1:0]  cfg_width_ff, cfg_width_in;
   logic [CFG_HEIGHT_W-1:0] cfg_height_ff, cfg_height_in;
   logic [CFG_RADIUS_W-1:0] cfg_radius_ff, cfg_radius_in;

   logic [COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;

   logic                    flush_ff, flush_in;
   logic signed [OFF_W-1:0] ky_ff, ky_in, kx_ff, kx_in;
   logic [AW-1:0]           row_base_ff, row_base_in;
   logic [3*CHAN_W-1:0]     pix_ff, pix_in;
   logic [CNT_W-1:0]        mid_ff, mid_in;
   logic [CNT_W-1:0]        sum_ff [3];
   logic [CNT_W-1:0]        sum_in [3];
   logic [2:0]              found_ff, found_in;
   logic [CHAN_W-1:0]       med_ff [3];
   logic [CHAN_W-1:0]       med_in [3];
   logic [CHAN_W-1:0]       alpha_ff, alpha_in;
   logic [SCAN_W-1:0]       scan_ff, scan_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]   rsp_red_ff, rsp_red_in, rsp_green_ff, rsp_green_in;
   logic [CHAN_W-1:0]   rsp_blue_ff, rsp_blue_in, rsp_alpha_ff, rsp_alpha_in;
   logic                rsp_end_ff, rsp_end_in;

   // Effective register values and derived terms.
   logic [EW_W-1:0]         eff_w;
   logic [ROW_W-1:0]        eff_h;
   logic [RAD_W-1:0]        eff_r;
   logic signed [OFF_W-1:0] pos_r, neg_r;
   logic [RAD_W:0]          side;
   logic [2*RAD_W+3:0]      side_sq;

   // Window address arithmetic.
   logic signed [PYW-1:0] pyi, py_c, hmax, dy;
   logic signed [SW-1:0]  slot_s, slot_w;
   logic signed [PXW-1:0] pxi, px_c, wmax;
   logic [AW-1:0]         out_base, in_base;

   // Handshake and position terms.
   logic              req_fire, pix_ok, start;
   logic              in_col_last, out_col_last, out_row_last, load;
   logic [ROW_W-1:0]  out_row_inc;
   logic [BIN_W-1:0]  prev_bin;
   logic [CNT_W-1:0]  nsum [3];

   // Memory ports.
   logic              ls_we;
   logic [AW-1:0]     ls_waddr, ls_raddr;
   logic [PIX_W-1:0]  ls_wdata, ls_rdata;
   logic              h_we;
   logic [BIN_W-1:0]  h_waddr [3];
   logic [BIN_W-1:0]  h_raddr [3];
   logic [CNT_W-1:0]  h_wdata [3];
   logic [CNT_W-1:0]  h_rdata [3];

   // Out of range register values are clamped to the supported range.
   always_comb begin
      if (cfg_width_ff == '0) begin
         eff_w = EW_W'(1);
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         eff_w = EW_W'(MAX_WIDTH);
      end else begin
         eff_w = EW_W'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         eff_h = ROW_W'(1);
      end else if (32'(cfg_height_ff) > HEIGHT_LIMIT) begin
         eff_h = ROW_W'(HEIGHT_LIMIT);
      end else begin
         eff_h = ROW_W'(cfg_height_ff);
      end
      if (cfg_radius_ff == '0) begin
         eff_r = RAD_W'(1);
      end else if (32'(cfg_radius_ff) > MAX_RADIUS) begin
         eff_r = RAD_W'(MAX_RADIUS);
      end else begin
         eff_r = RAD_W'(cfg_radius_ff);
      end
   end

   assign pos_r   = $signed(OFF_W'(eff_r));
   assign neg_r   = -pos_r;
   assign side    = {eff_r, 1'b1};
   assign side_sq = (2*RAD_W+4)'(side) * (2*RAD_W+4)'(side);

   // Clamped window row, turned into its slot in the line ring.
   always_comb begin
      pyi  = $signed(PYW'(out_row_ff)) + PYW'(ky_ff);
      hmax = $signed(PYW'(eff_h)) - PYW'(1);
      if (pyi < 0) begin
         py_c = '0;
      end else if (pyi > hmax) begin
         py_c = hmax;
      end else begin
         py_c = pyi;
      end
      dy     = py_c - $signed(PYW'(out_row_ff));
      slot_s = $signed(SW'(out_slot_ff)) + SW'(dy);
      if (slot_s < 0) begin
         slot_w = slot_s + $signed(SW'(LINES));
      end else if (slot_s >= $signed(SW'(LINES))) begin
         slot_w = slot_s - $signed(SW'(LINES));
      end else begin
         slot_w = slot_s;
      end
   end

   // Clamped window column.
   always_comb begin
      pxi  = $signed(PXW'(out_col_ff)) + PXW'(kx_ff);
      wmax = $signed(PXW'(eff_w)) - PXW'(1);
      if (pxi < 0) begin
         px_c = '0;
      end else if (pxi > wmax) begin
         px_c = wmax;
      end else begin
         px_c = pxi;
      end
   end

   assign out_base = AW'(out_slot_ff) * AW'(MAX_WIDTH);
   assign in_base  = AW'(in_slot_ff) * AW'(MAX_WIDTH);

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign pix_ok       = (req_op == OP_PIXEL) && (in_row_ff < eff_h);
   assign start        = req_fire && ((pix_ok && (in_row_ff > ROW_W'(eff_r)))
                         || ((req_op == OP_FLUSH) && (in_row_ff >= eff_h)));
   assign in_col_last  = (EW_W'(in_col_ff) + EW_W'(1)) >= eff_w;
   assign out_col_last = (EW_W'(out_col_ff) + EW_W'(1)) >= eff_w;
   assign out_row_inc  = out_row_ff + ROW_W'(1);
   assign out_row_last = out_row_inc >= eff_h;
   assign load         = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign prev_bin     = scan_ff[BIN_W-1:0] - BIN_W'(1);

   // Incoming pixels go straight into the line store.
   assign ls_we    = req_fire && pix_ok;
   assign ls_waddr = in_base + AW'(in_col_ff);
   assign ls_wdata = {req_in_alpha, req_in_blue, req_in_green, req_in_red};

   // Line store read address: centre pixel first, then the window.
   always_comb begin
      if (state_ff == ST_ALPHA) begin
         ls_raddr = out_base + AW'(out_col_ff);
      end else begin
         ls_raddr = row_base_ff + AW'(px_c);
      end
   end

   // Histogram ports: increment, scan with clear, and the reset sweep.
   always_comb begin
      h_we = 1'b0;
      for (int c = 0; c < 3; c++) begin
         h_raddr[c] = scan_ff[BIN_W-1:0];
         h_waddr[c] = scan_ff[BIN_W-1:0];
         h_wdata[c] = '0;
         nsum[c]    = sum_ff[c] + h_rdata[c];
      end
      unique case (state_ff)
         ST_CLEAR: begin
            h_we = 1'b1;
         end
         ST_HREAD: begin
            for (int c = 0; c < 3; c++) begin
               h_raddr[c] = ls_rdata[CHAN_W*c +: CHAN_W];
            end
         end
         ST_HWRITE: begin
            h_we = 1'b1;
            for (int c = 0; c < 3; c++) begin
               h_waddr[c] = pix_ff[CHAN_W*c +: CHAN_W];
               h_wdata[c] = h_rdata[c] + CNT_W'(1);
            end
         end
         ST_SCAN: begin
            h_we = (scan_ff != '0);
            for (int c = 0; c < 3; c++) begin
               h_waddr[c] = prev_bin;
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer and counters.
   always_comb begin
      state_in      = state_ff;
      cfg_width_in  = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      cfg_radius_in = cfg_radius_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      in_slot_in    = in_slot_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      out_slot_in   = out_slot_ff;
      flush_in      = flush_ff;
      ky_in         = ky_ff;
      kx_in         = kx_ff;
      row_base_in   = row_base_ff;
      pix_in        = pix_ff;
      mid_in        = mid_ff;
      found_in      = found_ff;
      alpha_in      = alpha_ff;
      scan_in       = scan_ff;
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = sum_ff[c];
         med_in[c] = med_ff[c];
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_alpha_in = rsp_alpha_ff;
      rsp_end_in   = rsp_end_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && pix_ok) begin
               if (in_col_last) begin
                  in_col_in  = '0;
                  in_row_in  = in_row_ff + ROW_W'(1);
                  in_slot_in = (in_slot_ff == SLOT_W'(LINES - 1)) ? '0
                               : in_slot_ff + SLOT_W'(1);
               end else begin
                  in_col_in = in_col_ff + COL_W'(1);
               end
            end
            if (start) begin
               flush_in = (req_op == OP_FLUSH);
               state_in = ST_ALPHA;
            end
         end
         ST_CLEAR: begin
            scan_in = scan_ff + SCAN_W'(1);
            if (scan_ff == SCAN_W'(BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_ALPHA: begin
            mid_in   = CNT_W'(side_sq >> 1);
            ky_in    = neg_r;
            kx_in    = neg_r;
            found_in = '0;
            for (int c = 0; c < 3; c++) begin
               sum_in[c] = '0;
               med_in[c] = '0;
            end
            state_in = ST_ROWSET;
         end
         ST_ROWSET: begin
            if (ky_ff == neg_r) begin
               alpha_in = ls_rdata[PIX_W-1 -: CHAN_W];
            end
            row_base_in = AW'(SLOT_W'(slot_w)) * AW'(MAX_WIDTH);
            state_in    = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_HREAD;
         end
         ST_HREAD: begin
            pix_in   = ls_rdata[3*CHAN_W-1:0];
            state_in = ST_HWRITE;
         end
         ST_HWRITE: begin
            if (kx_ff == pos_r) begin
               kx_in = neg_r;
               if (ky_ff == pos_r) begin
                  scan_in  = '0;
                  state_in = ST_SCAN;
               end else begin
                  ky_in    = ky_ff + OFF_W'(1);
                  state_in = ST_ROWSET;
               end
            end else begin
               kx_in    = kx_ff + OFF_W'(1);
               state_in = ST_FETCH;
            end
         end
         ST_SCAN: begin
            // Running count; the first bin that passes half the window wins.
            if (scan_ff != '0) begin
               for (int c = 0; c < 3; c++) begin
                  sum_in[c] = nsum[c];
                  if (!found_ff[c] && (nsum[c] > mid_ff)) begin
                     found_in[c] = 1'b1;
                     med_in[c]   = prev_bin;
                  end
               end
            end
            if (scan_ff == SCAN_W'(BINS)) begin
               state_in = ST_DONE;
            end else begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end
         ST_DONE: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_red_in   = med_ff[0];
               rsp_green_in = med_ff[1];
               rsp_blue_in  = med_ff[2];
               rsp_alpha_in = alpha_ff;
               rsp_end_in   = flush_ff && out_col_last && out_row_last;
               if (out_col_last) begin
                  out_col_in  = '0;
                  out_row_in  = out_row_inc;
                  out_slot_in = (out_slot_ff == SLOT_W'(LINES - 1)) ? '0
                                : out_slot_ff + SLOT_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
               // Last pixel of the frame: start the next one.
               if (flush_ff && out_col_last && out_row_last) begin
                  in_col_in   = '0;
                  in_row_in   = '0;
                  in_slot_in  = '0;
                  out_col_in  = '0;
                  out_row_in  = '0;
                  out_slot_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A write to one of the three registers restarts the frame.
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  cfg_width_in  = csr_wdata[CFG_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: cfg_height_in = csr_wdata[CFG_HEIGHT_W-1:0];
            CSR_RADIUS:       cfg_radius_in = csr_wdata[CFG_RADIUS_W-1:0];
            default: begin
            end
         endcase
         if (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT
             || csr_index == CSR_RADIUS) begin
            in_col_in   = '0;
            in_row_in   = '0;
            in_slot_in  = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            out_slot_in = '0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         scan_ff       <= '0;
         cfg_width_ff  <= CFG_WIDTH_W'(1);
         cfg_height_ff <= CFG_HEIGHT_W'(1);
         cfg_radius_ff <= CFG_RADIUS_W'(1);
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         in_slot_ff    <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         out_slot_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         cfg_width_ff  <= cfg_width_in;
         cfg_height_ff <= cfg_height_in;
         cfg_radius_ff <= cfg_radius_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         in_slot_ff    <= in_slot_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         out_slot_ff   <= out_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      flush_ff     <= flush_in;
      ky_ff        <= ky_in;
      kx_ff        <= kx_in;
      row_base_ff  <= row_base_in;
      pix_ff       <= pix_in;
      mid_ff       <= mid_in;
      found_ff     <= found_in;
      alpha_ff     <= alpha_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_alpha_ff <= rsp_alpha_in;
      rsp_end_ff   <= rsp_end_in;
      for (int c = 0; c < 3; c++) begin
         sum_ff[c] <= sum_in[c];
         med_ff[c] <= med_in[c];
      end
   end

   // Ring of row buffers.
   rgbamf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ls_we),
      .wr_addr (ls_waddr),
      .wr_data (ls_wdata),
      .rd_addr (ls_raddr),
      .rd_data (ls_rdata)
   );

   // One histogram per color channel.
   for (genvar g = 0; g < 3; g++) begin : g_hist
      rgbamf_ram #(
         .WIDTH (CNT_W),
         .DEPTH (BINS)
      ) u_hist (
         .clock   (clock),
         .wr_en   (h_we),
         .wr_addr (h_waddr[g]),
         .wr_data (h_wdata[g]),
         .rd_addr (h_raddr[g]),
         .rd_data (h_rdata[g])
      );
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_out_alpha = rsp_alpha_ff;
   assign rsp_frame_end = rsp_end_ff;

   // Output rows never run ahead of the rows received.
   a_out_behind_in: assert property (@(posedge clock) disable iff (reset)
      out_row_ff <= in_row_ff)
      else $error("output row ahead of input row");

   // Input column stays inside the row.
   a_in_col_range: assert property (@(posedge clock) disable iff (reset)
      EW_W'(in_col_ff) < eff_w)
      else $error("input column out of range");

   // Ring slots stay inside the line store.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (in_slot_ff < SLOT_W'(LINES - 1) || in_slot_ff == SLOT_W'(LINES - 1))
      && (out_slot_ff < SLOT_W'(LINES - 1) || out_slot_ff == SLOT_W'(LINES - 1)))
      else $error("line slot out of range");

   // A finished pixel that can be loaded shows up on the response port.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("finished pixel not presented");

   // Every channel has found its median by the end of the scan.
   a_median_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (found_ff == 3'b111))
      else $error("median not found in scan");

endmodule

[design/rgbamf_ram.sv]
module rgbamf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import rgbamf_pkg::*;

   localparam int LINE_COUNT = 16;
   localparam int MAX_COLS   = 1024;
   localparam int IDLE_MAX   = 18;
   localparam int STALL_LIMIT = 6000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              frame_end;
   } filtered_pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_op = OP_PIXEL;
   logic [CHAN_W-1:0]    req_in_red = '0;
   logic [CHAN_W-1:0]    req_in_green = '0;
   logic [CHAN_W-1:0]    req_in_blue = '0;
   logic [CHAN_W-1:0]    req_in_alpha = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CHAN_W-1:0]    rsp_out_red;
   logic [CHAN_W-1:0]    rsp_out_green;
   logic [CHAN_W-1:0]    rsp_out_blue;
   logic [CHAN_W-1:0]    rsp_out_alpha;
   logic                 rsp_frame_end;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Shadow copy of the filter state.
   logic [PIX_W-1:0] shadow_lines [0:LINE_COUNT*MAX_COLS-1];
   int unsigned      cfg_width, cfg_height, cfg_radius;
   int unsigned      in_col, in_row, out_col, out_row;

   filtered_pixel_type expected_pixels [$];
   int               error_count;
   int               request_count;
   int               pixel_count;
   int               frame_count;
   bit               steady_mode;

   rgba_median_filter_core u_top (.*);

   always #2 clock = ~clock;

   // Effective register values after clamping.
   function automatic int unsigned width_used();
      if (cfg_width < 1) return 1;
      if (cfg_width > MAX_COLS) return MAX_COLS;
      return cfg_width;
   endfunction

   function automatic int unsigned height_used();
      if (cfg_height < 1) return 1;
      if (cfg_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return cfg_height;
   endfunction

   function automatic int unsigned radius_used();
      if (cfg_radius < 1) return 1;
      return cfg_radius;
   endfunction

   function automatic logic [PIX_W-1:0] line_read(int unsigned row, int unsigned col);
      return shadow_lines[(row % LINE_COUNT) * MAX_COLS + (col % MAX_COLS)];
   endfunction

   function automatic void frame_restart();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   // Median of each color channel over the clamped window around the output position.
   function automatic filtered_pixel_type window_median(int unsigned w, int unsigned h,
                                                        int unsigned r);
      int               hist [3][BINS];
      int               py, px, total, half;
      logic [PIX_W-1:0] sample;
      logic [CHAN_W-1:0] med [3];
      filtered_pixel_type res;
      half = ((2 * r + 1) * (2 * r + 1)) / 2;
      foreach (hist[c, b]) hist[c][b] = 0;
      for (int dy = -int'(r); dy <= int'(r); dy++) begin
         py = int'(out_row) + dy;
         if (py < 0) py = 0;
         if (py > int'(h) - 1) py = int'(h) - 1;
         for (int dx = -int'(r); dx <= int'(r); dx++) begin
            px = int'(out_col) + dx;
            if (px < 0) px = 0;
            if (px > int'(w) - 1) px = int'(w) - 1;
            sample = line_read(py, px);
            for (int c = 0; c < 3; c++) hist[c][sample[8*c +: 8]]++;
         end
      end
      for (int c = 0; c < 3; c++) begin
         total = 0;
         med[c] = '0;
         for (int b = 0; b < BINS; b++) begin
            total += hist[c][b];
            if (total > half) begin
               med[c] = CHAN_W'(b);
               break;
            end
         end
      end
      sample = line_read(out_row, out_col);
      res.red = med[0];
      res.green = med[1];
      res.blue = med[2];
      res.alpha = sample[31:24];
      res.frame_end = 1'b0;
      return res;
   endfunction

   // Returns true when the last pixel of the frame has gone out.
   function automatic bit step_output(int unsigned w, int unsigned h);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Update the shadow state for one accepted request and queue its output pixel.
   function automatic void predict_request(logic op, logic [PIX_W-1:0] pix);
      int unsigned     w, h, r;
      filtered_pixel_type res;
      w = width_used();
      h = height_used();
      r = radius_used();
      if (op == OP_PIXEL) begin
         if (in_row >= h) return;
         shadow_lines[(in_row % LINE_COUNT) * MAX_COLS + in_col] = pix;
         if (in_row > r) begin
            res = window_median(w, h, r);
            void'(step_output(w, h));
            expected_pixels.push_back(res);
         end
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      end else begin
         if (in_row < h) return;
         res = window_median(w, h, r);
         if (step_output(w, h)) begin
            res.frame_end = 1'b1;
            frame_count++;
            frame_restart();
         end
         expected_pixels.push_back(res);
      end
   endfunction

   function automatic int draw_gap();
      if (steady_mode) return 0;
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, IDLE_MAX);
   endfunction

   // Send one request; returns at the edge where it is accepted.
   task automatic send_request(logic op, logic [PIX_W-1:0] pix);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_in_red   <= pix[7:0];
      req_in_green <= pix[15:8];
      req_in_blue  <= pix[23:16];
      req_in_alpha <= pix[31:24];
      do @(posedge clock); while (!req_ready);
      predict_request(op, pix);
      request_count++;
      if (op == OP_PIXEL) pixel_count++;
   endtask

   // Hold off new requests until every queued output pixel has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Register write; the core must be idle.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      drain();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH: begin
            cfg_width = 32'(value[CFG_WIDTH_W-1:0]);
            frame_restart();
         end
         CSR_FRAME_HEIGHT: begin
            cfg_height = 32'(value[CFG_HEIGHT_W-1:0]);
            frame_restart();
         end
         CSR_RADIUS: begin
            cfg_radius = 32'(value[CFG_RADIUS_W-1:0]);
            frame_restart();
         end
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic configure(int w, int h, int r);
      write_reg(CSR_FRAME_WIDTH, CSR_W'(w));
      write_reg(CSR_FRAME_HEIGHT, CSR_W'(h));
      write_reg(CSR_RADIUS, CSR_W'(r));
   endtask

   function automatic logic [PIX_W-1:0] draw_pixel(int mode);
      logic [PIX_W-1:0] pix;
      pix = $urandom;
      case (mode)
         1: for (int c = 0; c < 4; c++) pix[8*c +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         2: for (int c = 0; c < 3; c++) pix[8*c +: 8] = 8'($urandom_range(0, 3) * 85);
         default: begin
         end
      endcase
      return pix;
   endfunction

   // Outputs still owed by flush requests once every pixel is in.
   function automatic int flushes_needed();
      int w, h, r;
      w = width_used();
      h = height_used();
      r = radius_used();
      return (h > r + 1) ? w * (r + 1) : w * h;
   endfunction

   // Default registers: a one-pixel frame, plus requests the core must drop.
   task automatic test_reset_defaults();
      send_request(OP_FLUSH, '0);
      send_request(OP_PIXEL, 32'hA5C3_3C5A);
      send_request(OP_PIXEL, 32'h1234_5678);
      send_request(OP_FLUSH, '0);
      send_request(OP_PIXEL, 32'hFFFF_FFFF);
      send_request(OP_FLUSH, '0);
      drain();
   endtask

   // Extreme channel values in a small frame that emits from pixels and flushes.
   task automatic test_extremes();
      configure(3, 4, 1);
      for (int i = 0; i < 12; i++)
         send_request(OP_PIXEL, (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
      for (int i = 0; i < flushes_needed(); i++) send_request(OP_FLUSH, '0);
      drain();
   endtask

   // Out-of-range register values and the unused register index.
   task automatic test_register_clamps();
      configure(0, 0, 0);
      write_reg(CSR_SPARE, 13'h1FFF);
      send_request(OP_PIXEL, 32'h00FF_80FF);
      send_request(OP_FLUSH, '0);
      configure(2047, 8191, 7);
      for (int i = 0; i < 4; i++) send_request(OP_PIXEL, draw_pixel(0));
      // A register write in mid-frame throws the partial frame away.
      configure(1, 9, 7);
      for (int i = 0; i < 9; i++) send_request(OP_PIXEL, draw_pixel(2));
      for (int i = 0; i < flushes_needed(); i++) send_request(OP_FLUSH, '0);
      drain();
   endtask

   // Random frames with random content, noise requests and broken frames.
   task automatic test_random_frames(int target);
      int w, h, r, total, mode, cut;
      while (request_count < target) begin
         steady_mode = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 9) == 0) begin
            r = 7;
            w = $urandom_range(1, 3);
            h = $urandom_range(1, 18);
         end else begin
            r = $urandom_range(1, 3);
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 10);
         end
         configure(w, h, r);
         mode = $urandom_range(0, 2);
         total = w * h;
         cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
         for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 30) == 0) send_request(OP_FLUSH, '0);
            if ($urandom_range(0, 40) == 0) drain();
            send_request(OP_PIXEL, draw_pixel(mode));
         end
         if (cut == total) begin
            if ($urandom_range(0, 4) == 0) send_request(OP_PIXEL, draw_pixel(0));
            for (int i = 0; i < flushes_needed(); i++) send_request(OP_FLUSH, '0);
         end
      end
      steady_mode = 1'b0;
      drain();
   endtask

   // Result side: stall for a random number of cycles before each output pixel.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each output pixel with the oldest expectation.
   always @(posedge clock) begin
      filtered_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("output pixel with none expected");
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_out_red !== want.red) begin
               $error("out_red: expected %0d, got %0d", want.red, rsp_out_red);
               error_count++;
            end
            if (rsp_out_green !== want.green) begin
               $error("out_green: expected %0d, got %0d", want.green, rsp_out_green);
               error_count++;
            end
            if (rsp_out_blue !== want.blue) begin
               $error("out_blue: expected %0d, got %0d", want.blue, rsp_out_blue);
               error_count++;
            end
            if (rsp_out_alpha !== want.alpha) begin
               $error("out_alpha: expected %0d, got %0d", want.alpha, rsp_out_alpha);
               error_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %0d, got %0d", want.frame_end, rsp_frame_end);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en)
         quiet = 0;
      else
         quiet++;
      if (quiet >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", quiet);
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      request_count = 0;
      pixel_count = 0;
      frame_count = 0;
      steady_mode = 1'b0;
      cfg_width = 1;
      cfg_height = 1;
      cfg_radius = 1;
      frame_restart();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extremes();
      test_register_clamps();
      test_random_frames(1300);
      repeat (20) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $error("%0d output pixels never arrived", expected_pixels.size());
         error_count++;
      end
      $display("Sent %0d requests (%0d pixels) and completed %0d frames", request_count,
               pixel_count, frame_count);
      $display("over random sizes, radii 1 to 7, clamped registers and dropped requests.");
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
